// ===== rtl/lmsd_pkg.sv =====
// Shared types and constants of the LED matrix scan driver.
package lmsd_pkg;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [1:0] MODE_PIXEL   = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;

	localparam logic BEAT_SHIFT = 1'b0;
	localparam logic BEAT_LATCH = 1'b1;

	localparam logic [15:0] SHOW_TIME_RESET = 16'd100;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_cmd_t;

endpackage

// ===== rtl/lmsd_frame_mem.sv =====
// Frame store: synchronous row memory with per-row valid flags, so one clear command blanks every row.
module lmsd_frame_mem #(
	parameter int PANEL_WIDTH  = 32,
	parameter int PANEL_HEIGHT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lmsd_pkg::mem_cmd_t              cmd,
	input  logic [$clog2(PANEL_HEIGHT)-1:0] rd_addr,
	input  logic [$clog2(PANEL_HEIGHT)-1:0] wr_addr,
	input  logic [PANEL_WIDTH-1:0]          wr_data,
	output logic [PANEL_WIDTH-1:0]          rd_data
);

	logic [PANEL_WIDTH-1:0]  mem [PANEL_HEIGHT];
	logic [PANEL_HEIGHT-1:0] row_vld_q;
	logic [PANEL_WIDTH-1:0]  rd_raw_s1;
	logic                    rd_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_raw_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr) begin
				row_vld_q <= '0;
			end else if (cmd.wr) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_s1 <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_raw_s1 : '0;

endmodule

// ===== rtl/lmsd_beat_gen.sv =====
// Beat generator: shifts out one row pair column by column, then the latch word.
module lmsd_beat_gen #(
	parameter int PANEL_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [PANEL_WIDTH-1:0]              top_row,
	input  logic [PANEL_WIDTH-1:0]              bot_row,
	input  logic [1:0]                          grp,
	input  logic [15:0]                         en_time,
	output logic                                busy,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lmsd_pkg::OUT_TDATA_W-1:0]    m_tdata,  // top_on, bottom_on, row_address[1:0], enable_time[15:0]
	output logic                                m_tuser,  // beat_kind
	output logic                                m_tlast
);

	localparam int CW = $clog2(PANEL_WIDTH + 1);

	logic [PANEL_WIDTH-1:0] top_q;
	logic [PANEL_WIDTH-1:0] bot_q;
	logic [1:0]             grp_q;
	logic [15:0]            en_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   vld_q;
	logic                   kind_q;
	logic                   top_on_q;
	logic                   bot_on_q;
	logic [1:0]             addr_out_q;
	logic [15:0]            en_out_q;
	logic                   adv;

	assign adv = busy_q && (!vld_q || m_tready);

	always_ff @(posedge clk) begin
		if (start) begin
			top_q <= top_row;
			bot_q <= bot_row;
			grp_q <= grp;
			en_q  <= en_time;
		end else if (adv) begin
			top_q <= top_q >> 1;
			bot_q <= bot_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			vld_q      <= 1'b0;
			kind_q     <= lmsd_pkg::BEAT_SHIFT;
			top_on_q   <= 1'b0;
			bot_on_q   <= 1'b0;
			addr_out_q <= '0;
			en_out_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				vld_q      <= 1'b1;
				addr_out_q <= grp_q;
				if (cnt_q == CW'(PANEL_WIDTH)) begin
					kind_q   <= lmsd_pkg::BEAT_LATCH;
					top_on_q <= 1'b0;
					bot_on_q <= 1'b0;
					en_out_q <= en_q;
					busy_q   <= 1'b0;
				end else begin
					kind_q   <= lmsd_pkg::BEAT_SHIFT;
					top_on_q <= top_q[0];
					bot_on_q <= bot_q[0];
					en_out_q <= '0;
					cnt_q    <= cnt_q + 1'b1;
				end
			end
			if (!adv && m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = vld_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = (kind_q == lmsd_pkg::BEAT_LATCH);
	assign m_tdata  = {4'b0, en_out_q, addr_out_q, bot_on_q, top_on_q};

endmodule

// ===== rtl/led_matrix_scan_driver.sv =====
// Throughput: a refresh gives PANEL_WIDTH+1 beats at one per cycle when unstalled;
// each item runs two row reads, the start of the beat generator, the beats, then the return to idle.
// The next item is taken while the latch beat still waits in the output register.
// Reset: frame reads as dark at once through per-row valid flags; show time resets to 100.
// Top level: command decode and read-modify-write sequencing over the frame store.
module led_matrix_scan_driver #(
	parameter int PANEL_WIDTH  = 32,
	parameter int PANEL_HEIGHT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lmsd_pkg::IN_TDATA_W-1:0]   s_tdata,  // pixel_x[4:0], pixel_y[3:0], pixel_on, row_group[1:0]
	input  logic [1:0]                        s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lmsd_pkg::OUT_TDATA_W-1:0]  m_tdata,  // top_on, bottom_on, row_address[1:0], enable_time[15:0]
	output logic                              m_tuser,  // beat_kind
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [15:0]                       cfg_data
);

	localparam int AW   = $clog2(PANEL_HEIGHT);
	localparam int XW   = $clog2(PANEL_WIDTH);
	localparam int HALF = PANEL_HEIGHT / 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIXEL,
		ST_RD_TOP,
		ST_RD_BOT,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [15:0]            show_time_q;
	logic [XW-1:0]          px_x_q;
	logic                   px_on_q;
	logic [AW-1:0]          px_row_q;
	logic [1:0]             grp_q;
	logic                   bot_dark_q;
	logic [PANEL_WIDTH-1:0] top_row_q;

	logic [4:0]             pixel_x;
	logic [3:0]             pixel_y;
	logic                   pixel_on;
	logic [1:0]             row_group;
	logic                   accept;
	logic                   px_in_range;
	logic                   bot_dark;
	logic [AW-1:0]          bot_addr;

	lmsd_pkg::mem_cmd_t     mem_cmd;
	logic [AW-1:0]          rd_addr;
	logic [PANEL_WIDTH-1:0] rd_data;
	logic [PANEL_WIDTH-1:0] wr_data;
	logic [PANEL_WIDTH-1:0] bot_row;
	logic                   bg_start;
	logic                   bg_busy;

	assign pixel_x   = s_tdata[4:0];
	assign pixel_y   = s_tdata[8:5];
	assign pixel_on  = s_tdata[9];
	assign row_group = s_tdata[11:10];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign px_in_range = (32'(pixel_x) < PANEL_WIDTH) && (32'(pixel_y) < PANEL_HEIGHT);
	assign bot_dark    = (32'(grp_q) + HALF) >= PANEL_HEIGHT;
	assign bot_addr    = bot_dark ? '0 : AW'(32'(grp_q) + HALF);

	always_comb begin
		mem_cmd = '0;
		rd_addr = '0;
		wr_data = rd_data;
		wr_data[px_x_q] = px_on_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						lmsd_pkg::MODE_PIXEL: begin
							mem_cmd.rd = px_in_range;
							rd_addr    = AW'(pixel_y);
						end
						lmsd_pkg::MODE_CLEAR: begin
							mem_cmd.clr = 1'b1;
						end
						lmsd_pkg::MODE_REFRESH: begin
							mem_cmd.rd = 1'b1;
							rd_addr    = AW'(row_group);
						end
						default: begin
						end
					endcase
				end
			end
			ST_PIXEL: begin
				mem_cmd.wr = 1'b1;
			end
			ST_RD_TOP: begin
				mem_cmd.rd = !bot_dark;
				rd_addr    = bot_addr;
			end
			default: begin
			end
		endcase
	end

	assign bg_start = (state_q == ST_RD_BOT);
	assign bot_row  = bot_dark_q ? '0 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			show_time_q <= lmsd_pkg::SHOW_TIME_RESET;
			px_x_q      <= '0;
			px_on_q     <= 1'b0;
			px_row_q    <= '0;
			grp_q       <= '0;
			bot_dark_q  <= 1'b0;
			top_row_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				show_time_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_x_q   <= XW'(pixel_x);
						px_on_q  <= pixel_on;
						px_row_q <= AW'(pixel_y);
						grp_q    <= row_group;
						if (s_tuser == lmsd_pkg::MODE_PIXEL && px_in_range) begin
							state_q <= ST_PIXEL;
						end else if (s_tuser == lmsd_pkg::MODE_REFRESH) begin
							state_q <= ST_RD_TOP;
						end
					end
				end
				ST_PIXEL: begin
					state_q <= ST_IDLE;
				end
				ST_RD_TOP: begin
					top_row_q  <= rd_data;
					bot_dark_q <= bot_dark;
					state_q    <= ST_RD_BOT;
				end
				ST_RD_BOT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!bg_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lmsd_frame_mem #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.rd_addr(rd_addr),
		.wr_addr(px_row_q),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	lmsd_beat_gen #(
		.PANEL_WIDTH(PANEL_WIDTH)
	) u_beat (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bg_start),
		.top_row (top_row_q),
		.bot_row (bot_row),
		.grp     (grp_q),
		.en_time (show_time_q),
		.busy    (bg_busy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== rtl/lmsd_checker.sv =====
// Port-level checks of the LED matrix scan driver, bound to the top level.
module lmsd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [1:0]                        s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lmsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                              m_tuser,
	input logic                              m_tlast
);

	a_last_is_latch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == lmsd_pkg::BEAT_LATCH)))
		else $error("tlast does not match latch word");

	a_latch_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[1:0] == 2'b00))
		else $error("latch word carries color bits");

	a_shift_no_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[19:4] == 16'd0))
		else $error("shift word carries enable time");

	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == lmsd_pkg::MODE_REFRESH) |=> !s_tready)
		else $error("input taken right after a refresh");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output word changed");

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (.*);

// ===== verif/led_matrix_scan_driver_tb.sv =====
// Self-checking testbench for led_matrix_scan_driver: directed table, then random phases.
`timescale 1ns / 1ps

module led_matrix_scan_driver_tb;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 63;
	localparam int LONG_HOLD_AT = 1200;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic        kind;
		logic        top;
		logic        bot;
		logic [1:0]  addr;
		logic [15:0] en;
		logic        last;
	} scan_beat_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  x;
		logic [3:0]  y;
		logic        on;
		logic [1:0]  grp;
		logic        typed;
		logic [31:0] top;
		logic [31:0] bot;
		logic [15:0] tm;
	} stim_row_t;

	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd0, 1'b1, 32'h0, 32'h0, 16'd100},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd3, 1'b1, 32'h0, 32'h0, 16'd100},
		'{lmsd_pkg::MODE_PIXEL,   5'd0,  4'd0,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd31, 4'd8,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd31, 4'd0,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd0,  4'd8,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd0, 1'b1,
			32'h8000_0001, 32'h8000_0001, 16'd100},
		'{lmsd_pkg::MODE_PIXEL,   5'd31, 4'd0,  1'b0, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd0, 1'b1,
			32'h0000_0001, 32'h8000_0001, 16'd100},
		'{MODE_UNUSED,            5'd31, 4'd15, 1'b1, 2'd3, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd31, 4'd15, 1'b1, 2'd3, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd5,  4'd11, 1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd17, 4'd3,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd31, 4'd15, 1'b1, 2'd3, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd9,  4'd1,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd22, 4'd9,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd1, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_PIXEL,   5'd12, 4'd2,  1'b1, 2'd0, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd2, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_CLEAR,   5'd31, 4'd15, 1'b1, 2'd3, 1'b0, 32'h0, 32'h0, 16'd0},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd0, 1'b1, 32'h0, 32'h0, 16'd100},
		'{lmsd_pkg::MODE_REFRESH, 5'd0,  4'd0,  1'b0, 2'd3, 1'b1, 32'h0, 32'h0, 16'd100}
	};

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [lmsd_pkg::IN_TDATA_W-1:0]  s_tdata;   // pixel_x[4:0], pixel_y[3:0], pixel_on, row_group[1:0]
	logic [1:0]                       s_tuser;   // mode
	logic                             m_tvalid;
	logic                             m_tready;
	logic [lmsd_pkg::OUT_TDATA_W-1:0] m_tdata;   // top_on, bottom_on, row_address[1:0], enable_time[15:0]
	logic                             m_tuser;   // beat_kind
	logic                             m_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [15:0]                      cfg_data;

	// predicted panel state
	logic [31:0] frame_rows [16];
	logic [15:0] show_time;
	scan_beat_t  expected_beats [$];

	// typed expectation for the word now offered, directed table only
	logic        use_typed;
	logic [31:0] typed_top;
	logic [31:0] typed_bot;
	logic [15:0] typed_tm;

	logic        idle_on;
	logic        long_hold_done;
	int unsigned beats_seen;
	int unsigned errors;
	int unsigned cycle_count;

	led_matrix_scan_driver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] pack_word(input logic [4:0] x, input logic [3:0] y,
			input logic on, input logic [1:0] grp);
		return {4'b0, grp, on, y, x};
	endfunction

	task automatic queue_refresh(input logic [1:0] grp, input logic [31:0] top,
			input logic [31:0] bot, input logic [15:0] tm);
		for (int c = 0; c < 32; c++)
			expected_beats.push_back('{lmsd_pkg::BEAT_SHIFT, top[c], bot[c], grp, 16'd0, 1'b0});
		expected_beats.push_back('{lmsd_pkg::BEAT_LATCH, 1'b0, 1'b0, grp, tm, 1'b1});
	endtask

	task automatic predict_scan_word(input logic [1:0] mode, input logic [15:0] data);
		logic [4:0] x;
		logic [3:0] y;
		logic [1:0] grp;
		x = data[4:0];
		y = data[8:5];
		grp = data[11:10];
		case (mode)
			lmsd_pkg::MODE_PIXEL: frame_rows[y][x] = data[9];
			lmsd_pkg::MODE_CLEAR: begin
				for (int r = 0; r < 16; r++)
					frame_rows[r] = '0;
			end
			lmsd_pkg::MODE_REFRESH: begin
				if (use_typed)
					queue_refresh(grp, typed_top, typed_bot, typed_tm);
				else
					queue_refresh(grp, frame_rows[{2'b00, grp}], frame_rows[{2'b10, grp}],
						show_time);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				show_time = cfg_data;
			if (s_tvalid && s_tready)
				predict_scan_word(s_tuser, s_tdata);
		end
	end

	always @(posedge clk) begin
		scan_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				$error("unexpected word: tdata=%h tuser=%b tlast=%b", m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				if (m_tuser !== want.kind) begin
					$error("beat_kind: expected %0d, got %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata[0] !== want.top) begin
					$error("top_on: expected %0d, got %0d", want.top, m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== want.bot) begin
					$error("bottom_on: expected %0d, got %0d", want.bot, m_tdata[1]);
					errors++;
				end
				if (m_tdata[3:2] !== want.addr) begin
					$error("row_address: expected %0d, got %0d", want.addr, m_tdata[3:2]);
					errors++;
				end
				if (m_tdata[19:4] !== want.en) begin
					$error("enable_time: expected %0d, got %0d", want.en, m_tdata[19:4]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_beat: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random ready pattern, plus one long hold-off to back the block up
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (!long_hold_done && beats_seen >= LONG_HOLD_AT) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
			end else if (!idle_on || $urandom_range(0, 99) < 60) begin
				@(negedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 29)) @(negedge clk);
			end else begin
				@(negedge clk);
				m_tready <= 1'b0;
				if ($urandom_range(0, 9) < 8)
					repeat ($urandom_range(0, 2)) @(negedge clk);
				else
					repeat ($urandom_range(5, 30)) @(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_scan_word(input logic [1:0] mode, input logic [15:0] data,
			input logic typed, input logic [31:0] top, input logic [31:0] bot,
			input logic [15:0] tm, input int gap);
		@(negedge clk);
		use_typed = typed;
		typed_top = top;
		typed_bot = bot;
		typed_tm = tm;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_show_time(input logic [15:0] value);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		stim_row_t   row;
		logic [1:0]  mode;
		logic [1:0]  grp;
		logic [3:0]  y;
		logic [15:0] value;
		int          r;
		int          sent;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lmsd_pkg::MODE_PIXEL;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		use_typed = 1'b0;
		typed_top = '0;
		typed_bot = '0;
		typed_tm = '0;
		idle_on = 1'b1;
		long_hold_done = 1'b0;
		beats_seen = 0;
		errors = 0;
		cycle_count = 0;
		show_time = lmsd_pkg::SHOW_TIME_RESET;
		for (int i = 0; i < 16; i++)
			frame_rows[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			send_scan_word(row.mode, pack_word(row.x, row.y, row.on, row.grp), row.typed,
				row.top, row.bot, row.tm, pick_gap());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		use_typed = 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       value = 16'd0;
				1:       value = 16'hFFFF;
				2:       value = 16'd1;
				5:       value = lmsd_pkg::SHOW_TIME_RESET;
				default: value = 16'($urandom);
			endcase
			write_show_time(value);
			idle_on = (phase != 2);
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					mode = lmsd_pkg::MODE_PIXEL;
				else if (r < 90)
					mode = lmsd_pkg::MODE_REFRESH;
				else if (r < 93)
					mode = lmsd_pkg::MODE_CLEAR;
				else
					mode = MODE_UNUSED;
				if (mode != MODE_UNUSED)
					sent++;
				grp = 2'($urandom_range(0, 3));
				// mostly rows that a refresh can show
				if ($urandom_range(0, 3) == 0)
					y = 4'($urandom_range(0, 15));
				else
					y = {1'($urandom_range(0, 1)), 1'b0, 2'($urandom_range(0, 3))};
				send_scan_word(mode, pack_word(5'($urandom_range(0, 31)), y,
					$urandom_range(0, 9) < 7, grp), 1'b0, '0, '0, '0, pick_gap());
			end
			@(negedge clk);
			s_tvalid <= 1'b0;
		end

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
